/* design/sfb_pkg.sv */
// Shared types and constants for the sample framer with burst buffer.
package sfb_pkg;

    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_D = 8'h64;

    localparam logic [7:0] KIND_ACK = 8'(6 << 5);
    localparam logic [7:0] KIND_END = 8'(7 << 5);

    localparam logic [7:0] ACK_INVALID = 8'd1;
    localparam logic [7:0] ACK_MODE    = 8'd2;
    localparam logic [7:0] ACK_MASK    = 8'd3;
    localparam logic [7:0] ACK_FREQ    = 8'd4;
    localparam logic [7:0] ACK_END     = 8'd0;

    typedef struct packed {
        logic       cmd;
        logic [2:0] next_chan;
        logic [9:0] sample_value;
        logic [7:0] msg_byte0;
        logic [7:0] msg_byte1;
        logic [7:0] msg_byte2;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  frame_hi;
        logic [7:0]  frame_lo;
        logic        freq_update;
        logic [15:0] freq_value;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [2:0] chan;
        logic [9:0] value;
    } t_frame;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_FLUSH,
        S_ACK
    } t_state;

endpackage

/* design/sfb_cell.sv */
// One slot of the frame store: loads a new frame or takes its neighbour's.
module sfb_cell
    import sfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  t_frame i_load_frame,
    input  logic   i_shift,
    input  t_frame i_next_frame,
    output t_frame o_frame
);

    t_frame r_frame;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_load_frame;
        end else if (i_shift) begin
            r_frame <= i_next_frame;
        end
    end

    assign o_frame = r_frame;

endmodule

/* design/sample_framer_with_burst_buffer_unit.sv */
// Top level of the sample framer with burst buffer.
// Each accepted item is latched and decoded in the following cycle; an item
// that yields a beat waits in decode while the output is stalled. A flush
// empties the chain of STORE_DEPTH store cells one frame per cycle through
// cell zero while the output is not stalled, so a flush caused by a full
// store sends STORE_DEPTH frames, and a flush caused by leaving buffered
// mode sends each held frame followed by the acknowledgment. A finished beat
// waits in the output register while the next item is taken in.
module sample_framer_with_burst_buffer_unit
    import sfb_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int FILL_W = $clog2(STORE_DEPTH + 1);

    t_state           r_state, n_state;
    t_in_beat         r_item;
    logic             r_buffered;
    logic [7:0]       r_mask;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_remain;
    logic             r_ack_pend;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic             out_free;
    logic [2:0]       chan;
    logic             hit;
    logic             is_mode;
    logic             mode_flush;
    logic             fill_full;
    t_frame           new_frame;
    t_frame           cell_frame [STORE_DEPTH];

    logic             emit;
    t_out_beat        beat;
    logic             push;
    logic             shift;
    logic             start_flush;
    logic [FILL_W-1:0] flush_cnt;
    logic             set_mode;
    logic             set_mask;
    logic [7:0]       mask_val;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign chan       = r_item.next_chan - 3'd1;
    assign hit        = r_mask[chan];
    assign is_mode    = (r_item.msg_byte0 == CH_M)
                        && ((r_item.msg_byte1 == CH_C) || (r_item.msg_byte1 == CH_B));
    assign mode_flush = is_mode && r_buffered && (r_item.msg_byte1 == CH_C)
                        && (r_fill != '0);
    assign fill_full  = (r_fill == FILL_W'(STORE_DEPTH - 1));
    assign new_frame  = '{chan: chan, value: r_item.sample_value};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!r_item.cmd) begin
                    if (!hit) begin
                        n_state = S_IDLE;
                    end else if (r_buffered) begin
                        n_state = fill_full ? S_FLUSH : S_IDLE;
                    end else if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (mode_flush) begin
                    n_state = S_FLUSH;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free && (r_remain == FILL_W'(1))) begin
                    n_state = r_ack_pend ? S_ACK : S_IDLE;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        emit        = 1'b0;
        beat        = '0;
        push        = 1'b0;
        shift       = 1'b0;
        start_flush = 1'b0;
        flush_cnt   = '0;
        set_mode    = 1'b0;
        set_mask    = 1'b0;
        mask_val    = '0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_DECODE: begin
                if (!r_item.cmd) begin
                    if (hit) begin
                        if (r_buffered) begin
                            push = 1'b1;
                            if (fill_full) begin
                                start_flush = 1'b1;
                                flush_cnt   = FILL_W'(STORE_DEPTH);
                            end
                        end else if (out_free) begin
                            emit          = 1'b1;
                            beat.frame_hi = {3'b000, chan, r_item.sample_value[9:8]};
                            beat.frame_lo = r_item.sample_value[7:0];
                            beat.last     = 1'b1;
                        end
                    end
                end else if (mode_flush) begin
                    start_flush = 1'b1;
                    flush_cnt   = r_fill;
                    set_mode    = 1'b1;
                end else if (out_free) begin
                    emit          = 1'b1;
                    beat.frame_hi = KIND_ACK;
                    beat.last     = 1'b1;
                    if (is_mode) begin
                        set_mode      = 1'b1;
                        beat.frame_lo = ACK_MODE;
                    end else if (r_item.msg_byte0 == CH_C) begin
                        set_mask      = 1'b1;
                        mask_val      = r_item.msg_byte1;
                        beat.frame_lo = ACK_MASK;
                    end else if (r_item.msg_byte0 == CH_F) begin
                        beat.frame_lo    = ACK_FREQ;
                        beat.freq_update = 1'b1;
                        beat.freq_value  = {r_item.msg_byte1, r_item.msg_byte2};
                    end else if ((r_item.msg_byte0 == CH_E) && (r_item.msg_byte1 == CH_N)
                                 && (r_item.msg_byte2 == CH_D)) begin
                        set_mask      = 1'b1;
                        beat.frame_hi = KIND_END;
                        beat.frame_lo = ACK_END;
                    end else begin
                        beat.frame_lo = ACK_INVALID;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    emit          = 1'b1;
                    shift         = 1'b1;
                    beat.frame_hi = {3'b000, cell_frame[0].chan, cell_frame[0].value[9:8]};
                    beat.frame_lo = cell_frame[0].value[7:0];
                    beat.last     = (r_remain == FILL_W'(1)) && !r_ack_pend;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    emit          = 1'b1;
                    beat.frame_hi = KIND_ACK;
                    beat.frame_lo = ACK_MODE;
                    beat.last     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_buffered  <= 1'b0;
            r_mask      <= '0;
            r_fill      <= '0;
            r_remain    <= '0;
            r_ack_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (set_mode) begin
                r_buffered <= (r_item.msg_byte1 == CH_B);
            end
            if (set_mask) begin
                r_mask <= mask_val;
            end
            if (start_flush) begin
                r_fill <= '0;
            end else if (push) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (start_flush) begin
                r_remain   <= flush_cnt;
                r_ack_pend <= r_item.cmd;
            end else if (shift) begin
                r_remain <= r_remain - FILL_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_item <= i_in_beat;
        end
        if (emit) begin
            r_out <= beat;
        end
    end

    for (genvar gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
        t_frame next_frame;
        if (gi == STORE_DEPTH - 1) begin : g_tail
            assign next_frame = cell_frame[gi];
        end else begin : g_body
            assign next_frame = cell_frame[gi + 1];
        end
        sfb_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (push && (r_fill == FILL_W'(gi))),
            .i_load_frame (new_frame),
            .i_shift      (shift),
            .i_next_frame (next_frame),
            .o_frame      (cell_frame[gi])
        );
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

/* sim/tb_top.sv */
// Testbench for the sample framer: directed, burst, back-pressure and random traffic checks.
module tb_top;
    import sfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH    = 64;
    localparam int SETTLE_CYCLES  = STORE_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int PART_FILL      = 16;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    logic      mode_buffered;
    logic [7:0] chan_mask;
    t_frame    held_frames[$];
    t_out_beat frames_due[$];
    t_out_beat want_beat;

    bit        idle_on     = 1'b1;
    int        hold_req    = 0;
    int        err_count   = 0;
    int        quiet_cycles = 0;

    sample_framer_with_burst_buffer_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_frame_beat(logic [7:0] hi, logic [7:0] lo, logic fu,
                                            logic [15:0] fv);
        t_out_beat o;
        o.frame_hi    = hi;
        o.frame_lo    = lo;
        o.freq_update = fu;
        o.freq_value  = fv;
        o.last        = 1'b0;
        frames_due.push_back(o);
    endfunction

    function automatic void flush_held_frames();
        foreach (held_frames[i]) begin
            push_frame_beat({3'b000, held_frames[i].chan, held_frames[i].value[9:8]},
                            held_frames[i].value[7:0], 1'b0, 16'h0000);
        end
        held_frames.delete();
    endfunction

    function automatic void frame_item(t_in_beat b);
        int         n_before;
        logic [2:0] ch;
        t_frame     f;
        n_before = frames_due.size();
        if (b.cmd == 1'b0) begin
            ch = b.next_chan - 3'd1;
            f.chan  = ch;
            f.value = b.sample_value;
            if (chan_mask[ch]) begin
                if (!mode_buffered) begin
                    push_frame_beat({3'b000, ch, b.sample_value[9:8]}, b.sample_value[7:0],
                                    1'b0, 16'h0000);
                end else begin
                    held_frames.push_back(f);
                    if (held_frames.size() >= STORE_DEPTH)
                        flush_held_frames();
                end
            end
        end else if (b.msg_byte0 == CH_M && (b.msg_byte1 == CH_C || b.msg_byte1 == CH_B)) begin
            if (mode_buffered && b.msg_byte1 == CH_C)
                flush_held_frames();
            mode_buffered = (b.msg_byte1 == CH_B);
            push_frame_beat(KIND_ACK, ACK_MODE, 1'b0, 16'h0000);
        end else if (b.msg_byte0 == CH_C) begin
            chan_mask = b.msg_byte1;
            push_frame_beat(KIND_ACK, ACK_MASK, 1'b0, 16'h0000);
        end else if (b.msg_byte0 == CH_F) begin
            push_frame_beat(KIND_ACK, ACK_FREQ, 1'b1, {b.msg_byte1, b.msg_byte2});
        end else if (b.msg_byte0 == CH_E && b.msg_byte1 == CH_N && b.msg_byte2 == CH_D) begin
            chan_mask = 8'h00;
            push_frame_beat(KIND_END, ACK_END, 1'b0, 16'h0000);
        end else begin
            push_frame_beat(KIND_ACK, ACK_INVALID, 1'b0, 16'h0000);
        end
        if (frames_due.size() > n_before)
            frames_due[frames_due.size() - 1].last = 1'b1;
    endfunction

    function automatic t_in_beat mk_sample(logic [2:0] nc, logic [9:0] v);
        t_in_beat b;
        b.cmd          = 1'b0;
        b.next_chan    = nc;
        b.sample_value = v;
        b.msg_byte0    = 8'($urandom);
        b.msg_byte1    = 8'($urandom);
        b.msg_byte2    = 8'($urandom);
        return b;
    endfunction

    function automatic t_in_beat mk_cmd(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        t_in_beat b;
        b.cmd          = 1'b1;
        b.next_chan    = 3'($urandom);
        b.sample_value = 10'($urandom);
        b.msg_byte0    = b0;
        b.msg_byte1    = b1;
        b.msg_byte2    = b2;
        return b;
    endfunction

    task automatic send_beat(t_in_beat b);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        frame_item(b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_done();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_beat(mk_cmd(8'h00, 8'h00, 8'h00));
        send_beat(mk_cmd(8'hFF, 8'hFF, 8'hFF));
        send_beat(mk_sample(3'd1, 10'h3FF));
        send_beat(mk_cmd(CH_C, 8'hFF, 8'h00));
        send_beat(mk_sample(3'd0, 10'h3FF));
        send_beat(mk_sample(3'd1, 10'h000));
        send_beat(mk_sample(3'd7, 10'h2AA));
        send_beat(mk_cmd(CH_C, 8'h01, 8'hFF));
        send_beat(mk_sample(3'd2, 10'h155));
        send_beat(mk_sample(3'd1, 10'h155));
        send_beat(mk_cmd(CH_M, 8'h78, 8'h00));
        send_beat(mk_cmd(CH_M, CH_B, 8'h00));
        send_beat(mk_cmd(CH_C, 8'hFF, 8'h00));
        send_beat(mk_sample(3'd3, 10'h001));
        send_beat(mk_sample(3'd4, 10'h200));
        send_beat(mk_sample(3'd0, 10'h3FE));
        send_beat(mk_cmd(CH_M, CH_B, 8'hFF));
        send_beat(mk_sample(3'd6, 10'h0FF));
        send_beat(mk_cmd(CH_M, CH_C, 8'h00));
        send_beat(mk_cmd(CH_M, CH_C, 8'hFF));
        send_beat(mk_cmd(CH_F, 8'hFF, 8'hFF));
        send_beat(mk_cmd(CH_F, 8'h00, 8'h00));
        send_beat(mk_cmd(CH_E, CH_N, 8'h78));
        send_beat(mk_cmd(CH_E, 8'h78, CH_D));
        send_beat(mk_cmd(CH_E, CH_N, CH_D));
        send_beat(mk_sample(3'd5, 10'h123));
    endtask

    task automatic test_store_bursts();
        send_beat(mk_cmd(CH_M, CH_B, 8'($urandom)));
        send_beat(mk_cmd(CH_C, 8'hFF, 8'($urandom)));
        repeat (STORE_DEPTH) send_beat(mk_sample(3'($urandom), 10'($urandom)));
        wait_all_done();
        send_beat(mk_cmd(CH_C, 8'h0F, 8'($urandom)));
        while (held_frames.size() < PART_FILL)
            send_beat(mk_sample(3'($urandom), 10'($urandom)));
        send_beat(mk_cmd(CH_M, CH_C, 8'($urandom)));
        wait_all_done();
    endtask

    task automatic test_output_backpressure();
        send_beat(mk_cmd(CH_C, 8'hFF, 8'h00));
        hold_req = LONG_HOLD;
        repeat (16) send_beat(mk_sample(3'($urandom), 10'($urandom)));
        wait_all_done();
    endtask

    task automatic test_random_traffic(int n_items);
        int       r;
        t_in_beat b;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                b = mk_sample(3'($urandom), 10'($urandom));
            else if (r < 66)
                b = mk_cmd(CH_M, CH_C, 8'($urandom));
            else if (r < 72)
                b = mk_cmd(CH_M, CH_B, 8'($urandom));
            else if (r < 78)
                b = mk_cmd(CH_C, ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom),
                           8'($urandom));
            else if (r < 84)
                b = mk_cmd(CH_F, 8'($urandom), 8'($urandom));
            else if (r < 88)
                b = mk_cmd(CH_E, CH_N, CH_D);
            else if (r < 92)
                b = mk_cmd(8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 96)
                b = mk_cmd(CH_M, 8'($urandom), 8'($urandom));
            else
                b = mk_cmd(CH_E, 8'($urandom), 8'($urandom));
            send_beat(b);
        end
    endtask

    initial begin : rx_side
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, o_out_beat);
                err_count++;
            end else begin
                want_beat = frames_due.pop_front();
                if (o_out_beat.frame_hi !== want_beat.frame_hi
                        || o_out_beat.frame_lo !== want_beat.frame_lo
                        || o_out_beat.freq_update !== want_beat.freq_update
                        || o_out_beat.freq_value !== want_beat.freq_value
                        || o_out_beat.last !== want_beat.last) begin
                    $display("%0t: beat mismatch, expected hi %h lo %h fu %b fv %h last %b,",
                             $time, want_beat.frame_hi, want_beat.frame_lo,
                             want_beat.freq_update, want_beat.freq_value, want_beat.last,
                             " actual hi %h lo %h fu %b fv %h last %b",
                             o_out_beat.frame_hi, o_out_beat.frame_lo,
                             o_out_beat.freq_update, o_out_beat.freq_value, o_out_beat.last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        mode_buffered = 1'b0;
        chan_mask     = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_store_bursts();
        test_output_backpressure();
        test_random_traffic(30);
        idle_on = 1'b0;
        test_random_traffic(10);
        wait_all_done();
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
